// File: src/bfa_pkg.sv
// ---------------------------------------------------------------------------
// bfa_pkg
// Shared types, constants and the control store of the frame allocator.
// ---------------------------------------------------------------------------
`default_nettype none

package bfa_pkg;

   localparam int NUM_FRAMES = 64;
   localparam int IDX_W      = $clog2(NUM_FRAMES);
   localparam int CNT_W      = $clog2(NUM_FRAMES + 1);
   localparam int OP_W       = 2;
   localparam int UPC_W      = 4;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_ADDR_W-1:0] CSR_FRAMES_IN_USE = 2'd0;
   localparam logic [CNT_W-1:0]      FRAMES_RESET      = CNT_W'(NUM_FRAMES);

   localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
   localparam logic [OP_W-1:0] OP_FREE   = 2'd1;
   localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   // step addresses of the microprogram
   localparam logic [UPC_W-1:0] ST_IDLE      = 4'd0;
   localparam logic [UPC_W-1:0] ST_DECODE    = 4'd1;
   localparam logic [UPC_W-1:0] ST_SCAN      = 4'd2;
   localparam logic [UPC_W-1:0] ST_DRAIN     = 4'd3;
   localparam logic [UPC_W-1:0] ST_TEST      = 4'd4;
   localparam logic [UPC_W-1:0] ST_READ      = 4'd5;
   localparam logic [UPC_W-1:0] ST_GRANT     = 4'd6;
   localparam logic [UPC_W-1:0] ST_DONE      = 4'd7;
   localparam logic [UPC_W-1:0] ST_CHECK_OP  = 4'd8;
   localparam logic [UPC_W-1:0] ST_CHECK_IDX = 4'd9;
   localparam logic [UPC_W-1:0] ST_READ_IDX  = 4'd10;
   localparam logic [UPC_W-1:0] ST_ANSWER    = 4'd11;
   localparam logic [UPC_W-1:0] ST_FAIL      = 4'd12;
   localparam logic [UPC_W-1:0] ST_BAD       = 4'd13;

   typedef enum logic [1:0] {
      RD_NONE,
      RD_PTR,
      RD_IDX
   } rd_sel_type;

   typedef enum logic [2:0] {
      OUT_NONE,
      OUT_GRANT,
      OUT_FAIL,
      OUT_IDX,
      OUT_BAD
   } out_sel_type;

   typedef enum logic [3:0] {
      C_NEXT,
      C_ALWAYS,
      C_NO_ACCEPT,
      C_NOT_ALLOC,
      C_SCAN_MORE,
      C_FAIL,
      C_GRANT_MORE,
      C_UNUSED_OP,
      C_BAD_INDEX
   } cond_type;

   typedef struct packed {
      logic             in_ready;
      logic             need_out;
      logic             ptr_clr;
      logic             ptr_inc;
      logic             cnt_clr;
      logic             acc_en;
      rd_sel_type       rd_sel;
      out_sel_type      out_sel;
      cond_type         cond;
      logic [UPC_W-1:0] target;
   } ctrl_word_type;

   typedef struct packed {
      logic accepted;
      logic not_alloc;
      logic unused_op;
      logic bad_index;
      logic scan_more;
      logic alloc_fail;
      logic grant_more;
      logic out_busy;
   } status_type;

   function automatic ctrl_word_type make_cw(
      logic             in_ready,
      logic             need_out,
      logic             ptr_clr,
      logic             ptr_inc,
      logic             cnt_clr,
      logic             acc_en,
      rd_sel_type       rd_sel,
      out_sel_type      out_sel,
      cond_type         cond,
      logic [UPC_W-1:0] target
   );
      ctrl_word_type cw;
      cw.in_ready = in_ready;
      cw.need_out = need_out;
      cw.ptr_clr  = ptr_clr;
      cw.ptr_inc  = ptr_inc;
      cw.cnt_clr  = cnt_clr;
      cw.acc_en   = acc_en;
      cw.rd_sel   = rd_sel;
      cw.out_sel  = out_sel;
      cw.cond     = cond;
      cw.target   = target;
      return cw;
   endfunction

   // control store
   function automatic ctrl_word_type ucode(logic [UPC_W-1:0] upc);
      ctrl_word_type cw;
      unique case (upc)
         ST_IDLE:      cw = make_cw(1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0,
                                    RD_NONE, OUT_NONE, C_NO_ACCEPT, ST_IDLE);
         ST_DECODE:    cw = make_cw(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                                    RD_NONE, OUT_NONE, C_NOT_ALLOC, ST_CHECK_OP);
         ST_SCAN:      cw = make_cw(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1,
                                    RD_PTR, OUT_NONE, C_SCAN_MORE, ST_SCAN);
         ST_DRAIN:     cw = make_cw(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1,
                                    RD_NONE, OUT_NONE, C_NEXT, ST_IDLE);
         ST_TEST:      cw = make_cw(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                                    RD_NONE, OUT_NONE, C_FAIL, ST_FAIL);
         ST_READ:      cw = make_cw(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                                    RD_PTR, OUT_NONE, C_NEXT, ST_IDLE);
         ST_GRANT:     cw = make_cw(1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0,
                                    RD_NONE, OUT_GRANT, C_GRANT_MORE, ST_READ);
         ST_DONE:      cw = make_cw(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                                    RD_NONE, OUT_NONE, C_ALWAYS, ST_IDLE);
         ST_CHECK_OP:  cw = make_cw(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                                    RD_NONE, OUT_NONE, C_UNUSED_OP, ST_IDLE);
         ST_CHECK_IDX: cw = make_cw(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                                    RD_NONE, OUT_NONE, C_BAD_INDEX, ST_BAD);
         ST_READ_IDX:  cw = make_cw(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                                    RD_IDX, OUT_NONE, C_NEXT, ST_IDLE);
         ST_ANSWER:    cw = make_cw(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0,
                                    RD_NONE, OUT_IDX, C_ALWAYS, ST_IDLE);
         ST_FAIL:      cw = make_cw(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0,
                                    RD_NONE, OUT_FAIL, C_ALWAYS, ST_IDLE);
         ST_BAD:       cw = make_cw(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0,
                                    RD_NONE, OUT_BAD, C_ALWAYS, ST_IDLE);
         default:      cw = make_cw(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                                    RD_NONE, OUT_NONE, C_ALWAYS, ST_IDLE);
      endcase
      return cw;
   endfunction

endpackage

`default_nettype wire

// File: src/bfa_if.sv
// ---------------------------------------------------------------------------
// bfa request / response channels
// Valid-ready channels carrying one request word and one response word.
// ---------------------------------------------------------------------------
`default_nettype none

interface bfa_req_if;
   logic                          valid;
   logic                          ready;
   logic [bfa_pkg::OP_W-1:0]      opcode;
   logic [bfa_pkg::CNT_W-1:0]     frame_count;
   logic [bfa_pkg::IDX_W-1:0]     frame_index;

   modport source (output valid, output opcode, output frame_count, output frame_index,
                   input ready);
   modport sink (input valid, input opcode, input frame_count, input frame_index,
                 output ready);
endinterface

interface bfa_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bfa_pkg::IDX_W-1:0]     assigned_frame;
   logic                          granted;
   logic                          is_free;
   logic                          bad_index;
   logic                          last;

   modport source (output valid, output assigned_frame, output granted, output is_free,
                   output bad_index, output last, input ready);
   modport sink (input valid, input assigned_frame, input granted, input is_free,
                 input bad_index, input last, output ready);
endinterface

`default_nettype wire

// File: src/bfa_sequencer.sv
// ---------------------------------------------------------------------------
// bfa_sequencer
// Step counter, control store lookup and conditional branch selection.
// ---------------------------------------------------------------------------
`default_nettype none

module bfa_sequencer (
   input  wire                    clock,
   input  wire                    reset,
   input  bfa_pkg::status_type    status,
   output bfa_pkg::ctrl_word_type cw
);

   logic [bfa_pkg::UPC_W-1:0] upc_ff;
   logic [bfa_pkg::UPC_W-1:0] upc_in;
   logic                      jump;
   logic                      stall;

   assign cw    = bfa_pkg::ucode(upc_ff);
   assign stall = cw.need_out & status.out_busy;

   always_comb begin
      case (cw.cond)
         bfa_pkg::C_NEXT:       jump = 1'b0;
         bfa_pkg::C_ALWAYS:     jump = 1'b1;
         bfa_pkg::C_NO_ACCEPT:  jump = ~status.accepted;
         bfa_pkg::C_NOT_ALLOC:  jump = status.not_alloc;
         bfa_pkg::C_SCAN_MORE:  jump = status.scan_more;
         bfa_pkg::C_FAIL:       jump = status.alloc_fail;
         bfa_pkg::C_GRANT_MORE: jump = status.grant_more;
         bfa_pkg::C_UNUSED_OP:  jump = status.unused_op;
         bfa_pkg::C_BAD_INDEX:  jump = status.bad_index;
         default:               jump = 1'b1;
      endcase
   end

   always_comb begin
      if (stall) begin
         upc_in = upc_ff;
      end else if (jump) begin
         upc_in = cw.target;
      end else begin
         upc_in = upc_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= bfa_pkg::ST_IDLE;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

`default_nettype wire

// File: src/bfa_datapath.sv
// ---------------------------------------------------------------------------
// bfa_datapath
// Used-bit memory, scan pointer, counters, request latch and response register.
// ---------------------------------------------------------------------------
`default_nettype none

module bfa_datapath (
   input  wire                         clock,
   input  wire                         reset,
   input  wire [bfa_pkg::CNT_W-1:0]    frames,
   input  bfa_pkg::ctrl_word_type      cw,
   output bfa_pkg::status_type         status,
   bfa_req_if.sink                     req,
   bfa_rsp_if.source                   rsp
);

   // bitmap store: entries never written read as free
   logic                         mem [bfa_pkg::NUM_FRAMES];
   logic [bfa_pkg::NUM_FRAMES-1:0] wvalid_ff;

   logic [bfa_pkg::OP_W-1:0]     op_ff;
   logic [bfa_pkg::CNT_W-1:0]    count_ff;
   logic [bfa_pkg::IDX_W-1:0]    index_ff;
   logic [bfa_pkg::CNT_W-1:0]    ptr_ff;
   logic [bfa_pkg::CNT_W-1:0]    ptr_in;
   logic [bfa_pkg::CNT_W-1:0]    free_ff;
   logic [bfa_pkg::CNT_W-1:0]    free_in;
   logic [bfa_pkg::CNT_W-1:0]    k_ff;
   logic [bfa_pkg::CNT_W-1:0]    k_in;
   logic                         rd_ff;
   logic                         rdv_ff;
   logic                         rdv_in;

   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   logic [bfa_pkg::IDX_W-1:0]    frame_ff;
   logic                         granted_ff;
   logic                         is_free_ff;
   logic                         bad_ff;
   logic                         last_ff;

   logic                         act;
   logic                         accepted;
   logic                         ptr_ok;
   logic                         rd_en;
   logic [bfa_pkg::IDX_W-1:0]    rd_addr;
   logic                         wr_en;
   logic                         wr_data;
   logic [bfa_pkg::IDX_W-1:0]    wr_addr;
   logic                         grant_now;
   logic                         grant_last;
   logic                         load;
   logic                         out_busy;

   assign out_busy = rsp_valid_ff & ~rsp.ready;
   assign act      = ~(cw.need_out & out_busy);
   assign req.ready = cw.in_ready & ~reset;
   assign accepted = req.valid & req.ready;
   assign ptr_ok   = ptr_ff < frames;

   assign grant_now  = act & (cw.out_sel == bfa_pkg::OUT_GRANT) & ~rd_ff;
   assign grant_last = (k_ff + 1'b1) == count_ff;

   always_comb begin
      rd_en   = 1'b0;
      rd_addr = ptr_ff[bfa_pkg::IDX_W-1:0];
      case (cw.rd_sel)
         bfa_pkg::RD_PTR: rd_en = act & ptr_ok;
         bfa_pkg::RD_IDX: begin
            rd_en   = act;
            rd_addr = index_ff;
         end
         default:         rd_en = 1'b0;
      endcase
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_data = 1'b1;
      wr_addr = ptr_ff[bfa_pkg::IDX_W-1:0];
      if (grant_now) begin
         wr_en = 1'b1;
      end else if (act && cw.out_sel == bfa_pkg::OUT_IDX && op_ff == bfa_pkg::OP_FREE) begin
         wr_en   = 1'b1;
         wr_data = 1'b0;
         wr_addr = index_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr] & wvalid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wvalid_ff <= '0;
      end else if (wr_en) begin
         wvalid_ff[wr_addr] <= 1'b1;
      end
   end

   // request latch
   always_ff @(posedge clock) begin
      if (accepted) begin
         op_ff    <= req.opcode;
         count_ff <= req.frame_count;
         index_ff <= req.frame_index;
      end
   end

   always_comb begin
      ptr_in  = ptr_ff;
      free_in = free_ff;
      k_in    = k_ff;
      rdv_in  = act & (cw.rd_sel == bfa_pkg::RD_PTR) & ptr_ok;
      if (act) begin
         if (cw.ptr_clr) begin
            ptr_in = '0;
         end else if (cw.ptr_inc) begin
            ptr_in = ptr_ff + 1'b1;
         end
         if (cw.cnt_clr) begin
            free_in = '0;
            k_in    = '0;
         end else begin
            if (cw.acc_en && rdv_ff && !rd_ff) begin
               free_in = free_ff + 1'b1;
            end
            if (grant_now) begin
               k_in = k_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff  <= '0;
         free_ff <= '0;
         k_ff    <= '0;
         rdv_ff  <= 1'b0;
      end else begin
         ptr_ff  <= ptr_in;
         free_ff <= free_in;
         k_ff    <= k_in;
         rdv_ff  <= rdv_in;
      end
   end

   // response register
   always_comb begin
      case (cw.out_sel)
         bfa_pkg::OUT_GRANT: load = grant_now;
         bfa_pkg::OUT_FAIL,
         bfa_pkg::OUT_IDX,
         bfa_pkg::OUT_BAD:   load = act;
         default:            load = 1'b0;
      endcase
      if (load) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = out_busy;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         frame_ff   <= (cw.out_sel == bfa_pkg::OUT_GRANT) ? ptr_ff[bfa_pkg::IDX_W-1:0] : '0;
         granted_ff <= cw.out_sel == bfa_pkg::OUT_GRANT;
         is_free_ff <= (cw.out_sel == bfa_pkg::OUT_IDX) & (op_ff == bfa_pkg::OP_QUERY) & ~rd_ff;
         bad_ff     <= cw.out_sel == bfa_pkg::OUT_BAD;
         last_ff    <= (cw.out_sel != bfa_pkg::OUT_GRANT) | grant_last;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.assigned_frame = frame_ff;
   assign rsp.granted        = granted_ff;
   assign rsp.is_free        = is_free_ff;
   assign rsp.bad_index      = bad_ff;
   assign rsp.last           = last_ff;

   assign status.accepted   = accepted;
   assign status.not_alloc  = op_ff != bfa_pkg::OP_ALLOC;
   assign status.unused_op  = op_ff == bfa_pkg::OP_UNUSED;
   assign status.bad_index  = {1'b0, index_ff} >= frames;
   assign status.scan_more  = ({1'b0, ptr_ff} + 1'b1) < {1'b0, frames};
   assign status.alloc_fail = (count_ff == '0) | (free_ff < count_ff);
   assign status.grant_more = ~(grant_now & grant_last);
   assign status.out_busy   = out_busy;

endmodule

`default_nettype wire

// File: src/bitmap_frame_allocator.sv
// ---------------------------------------------------------------------------
// bitmap_frame_allocator
// Bitmap free-frame allocator with an APB-style register port.
// ---------------------------------------------------------------------------
// One used bit per frame, held in a single-port bitmap memory whose entries
// all read as free right after reset (no clearing pass). Frames below
// min(frames_in_use, 64) are managed. Requests are served one at a time by a
// microprogrammed sequencer. A free or query checks its opcode and index,
// reads the used bit and returns one word before the next request is taken;
// a bad index gives its word without the read, and the unused opcode gives
// no word at all. An allocate first counts free frames, then visits frames
// in rising order up to the last one granted, one response word per granted
// frame; a failed allocate gives one word. Either way the next request is
// taken only after the last response step.
// The bitmap port serves one read per cycle; response stalls hold the
// sequencer while a response word waits.
// ---------------------------------------------------------------------------
`default_nettype none

module bitmap_frame_allocator (
   input  wire                              clock,
   input  wire                              reset,
   bfa_req_if.sink                          req_chan,
   bfa_rsp_if.source                        rsp_chan,
   input  wire                              psel,
   input  wire                              penable,
   input  wire                              pwrite,
   input  wire [bfa_pkg::CSR_ADDR_W-1:0]    paddr,
   input  wire [bfa_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [bfa_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready
);

   logic [bfa_pkg::CNT_W-1:0] frames_ff;
   logic [bfa_pkg::CNT_W-1:0] frames_in;
   logic [bfa_pkg::CNT_W-1:0] frames_eff;
   bfa_pkg::ctrl_word_type    cw;
   bfa_pkg::status_type       status;

   assign pready = 1'b1;

   always_comb begin
      frames_in = frames_ff;
      if (psel && penable && pwrite && paddr == bfa_pkg::CSR_FRAMES_IN_USE) begin
         frames_in = pwdata[bfa_pkg::CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frames_ff <= bfa_pkg::FRAMES_RESET;
      end else begin
         frames_ff <= frames_in;
      end
   end

   always_comb begin
      if (paddr == bfa_pkg::CSR_FRAMES_IN_USE) begin
         prdata = {{(bfa_pkg::CSR_DATA_W - bfa_pkg::CNT_W){1'b0}}, frames_ff};
      end else begin
         prdata = '0;
      end
   end

   assign frames_eff = (frames_ff > bfa_pkg::FRAMES_RESET) ? bfa_pkg::FRAMES_RESET
                                                          : frames_ff;

   bfa_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cw     (cw)
   );

   bfa_datapath u_dp (
      .clock  (clock),
      .reset  (reset),
      .frames (frames_eff),
      .cw     (cw),
      .status (status),
      .req    (req_chan),
      .rsp    (rsp_chan)
   );

endmodule

`default_nettype wire

// File: tb/bitmap_frame_allocator_tb.sv
// ---------------------------------------------------------------------------
// bitmap_frame_allocator_tb
// Self-checking bench for the bitmap frame allocator: drives allocate, free,
// query and unused requests under random back-pressure, tracks the frame
// bitmap and the frame-count register on the side, and compares every
// response word in order against the words owed by the accepted requests.
// ---------------------------------------------------------------------------
module bitmap_frame_allocator_tb;

   localparam int SETTLE_CYCLES = 16;
   localparam int PHASE_REQS    = 56;
   localparam int NUM_PHASES    = 7;

   typedef struct packed {
      logic [bfa_pkg::IDX_W-1:0] frame;
      logic                      granted;
      logic                      is_free;
      logic                      bad_index;
      logic                      last;
   } rsp_word_type;

   logic                           clock;
   logic                           reset;
   logic                           psel;
   logic                           penable;
   logic                           pwrite;
   logic [bfa_pkg::CSR_ADDR_W-1:0] paddr;
   logic [bfa_pkg::CSR_DATA_W-1:0] pwdata;
   logic [bfa_pkg::CSR_DATA_W-1:0] prdata;
   logic                           pready;

   bfa_req_if req_chan ();
   bfa_rsp_if rsp_chan ();

   bitmap_frame_allocator DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   logic [bfa_pkg::NUM_FRAMES-1:0] used_map   = '0;
   logic [bfa_pkg::CNT_W-1:0]      frames_cfg = bfa_pkg::FRAMES_RESET;
   rsp_word_type                   owed_words[$];
   int                             fail_count  = 0;
   int                             words_seen  = 0;
   int                             cfg_writes  = 0;
   int                             sent_by_op[4] = '{0, 0, 0, 0};
   int                             req_gap_pct   = 0;
   int                             rsp_stall_pct = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #100_000_000;
      $display("Timeout, %0d response words still owed", owed_words.size());
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic int pick_gap();
      if ($urandom_range(0, 99) < 85)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic int active_frames();
      return (frames_cfg > bfa_pkg::NUM_FRAMES) ? bfa_pkg::NUM_FRAMES : int'(frames_cfg);
   endfunction

   function automatic int free_frames();
      int cnt;
      cnt = 0;
      for (int i = 0; i < active_frames(); i++)
         if (!used_map[i]) cnt++;
      return cnt;
   endfunction

   function automatic void owe_word(int frame, logic granted, logic is_free,
                                    logic bad_index, logic last);
      rsp_word_type w;
      w.frame     = frame[bfa_pkg::IDX_W-1:0];
      w.granted   = granted;
      w.is_free   = is_free;
      w.bad_index = bad_index;
      w.last      = last;
      owed_words.push_back(w);
   endfunction

   // bitmap update and owed response words for one accepted request
   function automatic void apply_request(logic [bfa_pkg::OP_W-1:0] op,
                                         logic [bfa_pkg::CNT_W-1:0] count,
                                         logic [bfa_pkg::IDX_W-1:0] idx);
      int n;
      int k;
      n = active_frames();
      case (op)
         bfa_pkg::OP_ALLOC: begin
            if (count == 0 || free_frames() < int'(count)) begin
               owe_word(0, 1'b0, 1'b0, 1'b0, 1'b1);
            end else begin
               k = 0;
               for (int i = 0; i < n && k < int'(count); i++) begin
                  if (!used_map[i]) begin
                     used_map[i] = 1'b1;
                     k++;
                     owe_word(i, 1'b1, 1'b0, 1'b0, k == int'(count));
                  end
               end
            end
         end
         bfa_pkg::OP_FREE, bfa_pkg::OP_QUERY: begin
            if (int'(idx) >= n) begin
               owe_word(0, 1'b0, 1'b0, 1'b1, 1'b1);
            end else if (op == bfa_pkg::OP_FREE) begin
               used_map[idx] = 1'b0;
               owe_word(0, 1'b0, 1'b0, 1'b0, 1'b1);
            end else begin
               owe_word(0, 1'b0, !used_map[idx], 1'b0, 1'b1);
            end
         end
         default: ;
      endcase
   endfunction

   // response side: random stalls, with stretches of none when the rate is zero
   initial begin
      int stall;
      stall = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            stall--;
         end else begin
            rsp_chan.ready <= 1'b1;
            if ($urandom_range(0, 99) < rsp_stall_pct) stall = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      rsp_word_type got;
      rsp_word_type exp;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.frame     = rsp_chan.assigned_frame;
         got.granted   = rsp_chan.granted;
         got.is_free   = rsp_chan.is_free;
         got.bad_index = rsp_chan.bad_index;
         got.last      = rsp_chan.last;
         words_seen++;
         if (owed_words.size() == 0) begin
            fail_count++;
            $display("%0t: unexpected word frame=%0d granted=%b free=%b bad=%b last=%b",
                     $time, got.frame, got.granted, got.is_free, got.bad_index, got.last);
         end else begin
            exp = owed_words.pop_front();
            if (got.frame !== exp.frame || got.granted !== exp.granted ||
                got.is_free !== exp.is_free || got.bad_index !== exp.bad_index ||
                got.last !== exp.last) begin
               fail_count++;
               $display("%0t: word mismatch expected frame=%0d granted=%b free=%b bad=%b last=%b",
                        $time, exp.frame, exp.granted, exp.is_free, exp.bad_index, exp.last);
               $display("%0t:                 actual frame=%0d granted=%b free=%b bad=%b last=%b",
                        $time, got.frame, got.granted, got.is_free, got.bad_index, got.last);
            end
         end
      end
   end

   // valid is left high on return so a zero-gap follow-up needs no toggle
   task automatic send_request(logic [bfa_pkg::OP_W-1:0] op, int count, int idx);
      int                        gap;
      logic [bfa_pkg::CNT_W-1:0] cnt_word;
      logic [bfa_pkg::IDX_W-1:0] idx_word;
      cnt_word = count[bfa_pkg::CNT_W-1:0];
      idx_word = idx[bfa_pkg::IDX_W-1:0];
      gap = ($urandom_range(0, 99) < req_gap_pct) ? pick_gap() : 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.opcode      <= op;
      req_chan.frame_count <= cnt_word;
      req_chan.frame_index <= idx_word;
      do @(posedge clock); while (!req_chan.ready);
      apply_request(op, cnt_word, idx_word);
      sent_by_op[op]++;
   endtask

   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      while (owed_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write, then read back in a back-to-back transfer
   task automatic write_frames_in_use(int value);
      logic [bfa_pkg::CNT_W-1:0]      val_word;
      logic [bfa_pkg::CSR_DATA_W-1:0] data_word;
      val_word  = value[bfa_pkg::CNT_W-1:0];
      data_word = '0;
      data_word[bfa_pkg::CNT_W-1:0] = val_word;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= bfa_pkg::CSR_FRAMES_IN_USE;
      pwdata  <= data_word;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      frames_cfg = val_word;
      cfg_writes++;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== data_word) begin
         fail_count++;
         $display("%0t: frames_in_use readback expected %0d, actual %0d",
                  $time, data_word, prdata);
      end
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic test_directed_ops();
      req_gap_pct   = 20;
      rsp_stall_pct = 20;
      send_request(bfa_pkg::OP_ALLOC, 0, 0);
      send_request(bfa_pkg::OP_ALLOC, 1, 0);
      send_request(bfa_pkg::OP_ALLOC, 3, 0);
      send_request(bfa_pkg::OP_QUERY, 0, 0);
      send_request(bfa_pkg::OP_QUERY, 0, 10);
      send_request(bfa_pkg::OP_FREE, 0, 2);
      send_request(bfa_pkg::OP_FREE, 0, 2);
      send_request(bfa_pkg::OP_QUERY, 0, 2);
      send_request(bfa_pkg::OP_ALLOC, 2, 0);
      send_request(bfa_pkg::OP_ALLOC, 64, 0);
      send_request(bfa_pkg::OP_ALLOC, 127, 63);
      send_request(bfa_pkg::OP_UNUSED, 127, 63);
      send_request(bfa_pkg::OP_QUERY, 0, 63);
      send_request(bfa_pkg::OP_FREE, 0, 63);
      send_request(bfa_pkg::OP_ALLOC, 59, 0);
      send_request(bfa_pkg::OP_ALLOC, 1, 0);
      send_request(bfa_pkg::OP_FREE, 0, 63);
      send_request(bfa_pkg::OP_FREE, 0, 0);
      send_request(bfa_pkg::OP_ALLOC, 2, 0);
      send_request(bfa_pkg::OP_QUERY, 0, 63);
      wait_idle();
   endtask

   task automatic test_register_extremes();
      write_frames_in_use(0);
      send_request(bfa_pkg::OP_ALLOC, 1, 0);
      send_request(bfa_pkg::OP_QUERY, 0, 0);
      send_request(bfa_pkg::OP_FREE, 0, 63);
      wait_idle();
      write_frames_in_use(1);
      send_request(bfa_pkg::OP_FREE, 0, 0);
      send_request(bfa_pkg::OP_QUERY, 0, 0);
      send_request(bfa_pkg::OP_ALLOC, 1, 0);
      send_request(bfa_pkg::OP_ALLOC, 1, 0);
      send_request(bfa_pkg::OP_QUERY, 0, 1);
      wait_idle();
      write_frames_in_use(100);
      send_request(bfa_pkg::OP_QUERY, 0, 63);
      send_request(bfa_pkg::OP_FREE, 0, 63);
      send_request(bfa_pkg::OP_FREE, 0, 5);
      send_request(bfa_pkg::OP_ALLOC, 2, 0);
      wait_idle();
      write_frames_in_use(127);
      send_request(bfa_pkg::OP_QUERY, 0, 5);
      send_request(bfa_pkg::OP_ALLOC, 1, 0);
      wait_idle();
      // shrink: upper frames keep their bits but drop out of reach
      write_frames_in_use(8);
      send_request(bfa_pkg::OP_QUERY, 0, 63);
      send_request(bfa_pkg::OP_FREE, 0, 7);
      send_request(bfa_pkg::OP_ALLOC, 3, 0);
      wait_idle();
      write_frames_in_use(bfa_pkg::NUM_FRAMES);
      send_request(bfa_pkg::OP_QUERY, 0, 63);
      send_request(bfa_pkg::OP_QUERY, 0, 8);
   endtask

   task automatic test_random_traffic();
      int                       settings[NUM_PHASES];
      logic [bfa_pkg::OP_W-1:0] op;
      int                       cnt;
      int                       idx;
      int                       accepted;
      int                       n;
      int                       r;
      int                       s;
      bit                       paused;
      settings[0] = bfa_pkg::NUM_FRAMES;
      settings[1] = $urandom_range(2, 63);
      settings[2] = 1;
      settings[3] = 100;
      settings[4] = $urandom_range(1, 64);
      settings[5] = 127;
      settings[6] = bfa_pkg::NUM_FRAMES;
      for (int p = 0; p < NUM_PHASES; p++) begin
         wait_idle();
         write_frames_in_use(settings[p]);
         req_gap_pct   = (p == 0) ? 0 : $urandom_range(0, 60);
         rsp_stall_pct = (p == 0) ? 0 : $urandom_range(0, 60);
         accepted = 0;
         paused   = 1'b0;
         while (accepted < PHASE_REQS) begin
            if (accepted == PHASE_REQS / 2 && !paused) begin
               wait_idle();
               paused = 1'b1;
            end
            n   = active_frames();
            r   = $urandom_range(0, 99);
            cnt = $urandom_range(0, 127);
            idx = (n > 0 && $urandom_range(0, 99) < 85) ? $urandom_range(0, n - 1)
                                                       : $urandom_range(0, 63);
            if (r < 45) begin
               op = bfa_pkg::OP_ALLOC;
               s  = $urandom_range(0, 99);
               if (s < 70)      cnt = $urandom_range(1, 4);
               else if (s < 82) cnt = $urandom_range(5, 16);
               else if (s < 88) cnt = (free_frames() > 0) ? free_frames() : 1;
               else if (s < 93) cnt = 0;
               else if (s < 97) cnt = $urandom_range(17, 64);
               else             cnt = $urandom_range(65, 127);
            end else if (r < 80) begin
               op = bfa_pkg::OP_FREE;
            end else if (r < 95) begin
               op = bfa_pkg::OP_QUERY;
            end else begin
               op = bfa_pkg::OP_UNUSED;
            end
            send_request(op, cnt, idx);
            if (op != bfa_pkg::OP_UNUSED) accepted++;
         end
      end
   endtask

   initial begin
      reset                <= 1'b1;
      psel                 <= 1'b0;
      penable              <= 1'b0;
      pwrite               <= 1'b0;
      paddr                <= '0;
      pwdata               <= '0;
      req_chan.valid       <= 1'b0;
      req_chan.opcode      <= bfa_pkg::OP_ALLOC;
      req_chan.frame_count <= '0;
      req_chan.frame_index <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_directed_ops();
      test_register_extremes();
      test_random_traffic();
      wait_idle();
      $display("Requests: %0d allocate, %0d free, %0d query, %0d unused opcode",
               sent_by_op[bfa_pkg::OP_ALLOC], sent_by_op[bfa_pkg::OP_FREE],
               sent_by_op[bfa_pkg::OP_QUERY], sent_by_op[bfa_pkg::OP_UNUSED]);
      $display("Checked %0d response words across %0d frame-count register writes",
               words_seen, cfg_writes);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
